// ----- rtl/vlpd_pkg.sv -----
// Shared constants and types for the varint length-prefix deframer.
package vlpd_pkg;

	localparam int unsigned MAX_PREFIX_BYTES = 5;
	localparam int unsigned CNT_W = $clog2(MAX_PREFIX_BYTES + 1);
	localparam int unsigned SHIFT_W = $clog2(7 * MAX_PREFIX_BYTES + 1);

	localparam logic [7:0]  GROUP_MASK    = 8'h7F;
	localparam logic [7:0]  MORE_FLAG     = 8'h80;
	localparam logic [15:0] MAX_LEN_RESET = 16'd10000;

	// One result beat as produced by the parser, plus its valid flag.
	typedef struct packed {
		logic       vld;
		logic [7:0] data;
		logic       last;
		logic       err;
	} result_t;

endpackage

// ----- rtl/vlpd_ifs.sv -----
// Valid/ready channel interfaces for the deframer byte input and result output.
interface vlpd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface vlpd_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       last_of_message;
	logic       frame_error;

	modport source (output valid, output payload_byte, output last_of_message,
		output frame_error, input ready);
	modport sink   (input valid, input payload_byte, input last_of_message,
		input frame_error, output ready);
endinterface

// ----- rtl/vlpd_parse.sv -----
// Prefix/payload parser: framing state and per-beat result decode.
module vlpd_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [7:0]        rx_byte,
	input  logic [15:0]       max_len,
	output vlpd_pkg::result_t res
);

	logic                       receiving_q;
	logic [31:0]                acc_q;
	logic [vlpd_pkg::CNT_W-1:0] cnt_q;
	logic [15:0]                rem_q;

	logic                       receiving_d;
	logic [31:0]                acc_d;
	logic [vlpd_pkg::CNT_W-1:0] cnt_d;
	logic [15:0]                rem_d;

	logic [vlpd_pkg::SHIFT_W-1:0] shift;
	logic [63:0]                  group_sh;
	logic [31:0]                  acc_new;
	logic [15:0]                  rem_dec;

	assign shift    = vlpd_pkg::SHIFT_W'(7 * cnt_q);
	assign group_sh = {56'd0, rx_byte & vlpd_pkg::GROUP_MASK} << shift;
	assign acc_new  = acc_q | group_sh[31:0];
	assign rem_dec  = rem_q - 16'd1;

	always_comb begin
		receiving_d = receiving_q;
		acc_d       = acc_q;
		cnt_d       = cnt_q;
		rem_d       = rem_q;
		res         = '0;
		if (receiving_q) begin
			res.vld  = 1'b1;
			res.data = rx_byte;
			rem_d    = rem_dec;
			if (rem_dec == 16'd0) begin
				res.last    = 1'b1;
				receiving_d = 1'b0;
				acc_d       = '0;
				cnt_d       = '0;
			end
		end else if ((rx_byte & vlpd_pkg::MORE_FLAG) != 8'd0) begin
			if (cnt_q == vlpd_pkg::CNT_W'(vlpd_pkg::MAX_PREFIX_BYTES - 1)) begin
				// prefix too long: error now, next byte starts over
				res.vld = 1'b1;
				res.err = 1'b1;
				acc_d   = '0;
				cnt_d   = '0;
				rem_d   = '0;
			end else begin
				acc_d = acc_new;
				cnt_d = cnt_q + vlpd_pkg::CNT_W'(1);
			end
		end else if (acc_new == 32'd0 || acc_new > {16'd0, max_len}) begin
			res.vld = 1'b1;
			res.err = 1'b1;
			acc_d   = '0;
			cnt_d   = '0;
			rem_d   = '0;
		end else begin
			receiving_d = 1'b1;
			rem_d       = acc_new[15:0];
			acc_d       = '0;
			cnt_d       = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiving_q <= 1'b0;
			acc_q       <= '0;
			cnt_q       <= '0;
			rem_q       <= '0;
		end else if (fire) begin
			receiving_q <= receiving_d;
			acc_q       <= acc_d;
			cnt_q       <= cnt_d;
			rem_q       <= rem_d;
		end
	end

endmodule

// ----- rtl/vlpd_out_reg.sv -----
// Output result register; frees itself when the receiver takes the beat.
module vlpd_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  vlpd_pkg::result_t res,
	output logic              can_load,
	vlpd_result_if.source     tx
);

	logic       valid_q;
	logic [7:0] data_q;
	logic       last_q;
	logic       err_q;

	assign can_load = !valid_q || tx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= res.vld;
		end else if (tx.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res.data;
			last_q <= res.last;
			err_q  <= res.err;
		end
	end

	assign tx.valid           = valid_q;
	assign tx.payload_byte    = data_q;
	assign tx.last_of_message = last_q;
	assign tx.frame_error     = err_q;

endmodule

// ----- rtl/varint_length_prefix_deframer_top.sv -----
// Top level of the varint length-prefix deframer.
//
// rx carries the received stream, one byte per beat. Each message opens with a
// base-128 varint length (low group first, bit 7 = more bytes follow), then the
// declared number of payload bytes. Prefix bytes give no result; each payload
// byte gives one tx beat, last_of_message set on the final one. A zero length,
// a length above max_message_length, or a prefix still continuing at its fifth
// byte gives one tx beat with frame_error set and payload_byte zero; the byte
// after that starts a new prefix.
//
// cfg_we/cfg_data write max_message_length (reset 10000); write only while idle.
//
// Latency: a result beat shows on tx the cycle after its rx beat is taken.
// Throughput: one rx beat per cycle, held only by the single output register.
// rx.ready is high while that register is empty or being taken this cycle, so
// once a result sits there with the receiver stalled, rx stalls that same cycle.
// Reset clears the framing state (waiting for a prefix) and empties tx.
module varint_length_prefix_deframer_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_data,
	vlpd_byte_if.sink     rx,
	vlpd_result_if.source tx
);

	logic              fire;
	logic              can_load;
	logic [15:0]       max_len_q;
	vlpd_pkg::result_t res;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= vlpd_pkg::MAX_LEN_RESET;
		end else if (cfg_we) begin
			max_len_q <= cfg_data;
		end
	end

	assign rx.ready = can_load;
	assign fire     = rx.valid && can_load;

	vlpd_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.rx_byte (rx.rx_byte),
		.max_len (max_len_q),
		.res     (res)
	);

	// every accepted beat reloads the output register (empty when no result)
	vlpd_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (fire),
		.res      (res),
		.can_load (can_load),
		.tx       (tx)
	);

endmodule

// ----- verif/varint_length_prefix_deframer_top_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the varint length-prefix deframer top level.
module varint_length_prefix_deframer_top_test;

	// One tx beat as the deframer should present it.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       err;
	} beat_t;

	// Tracks the framing state of the rx stream and, when asked to, queues the
	// tx beats that the accepted bytes must produce and checks them in order.
	class deframe_check;
		bit          keep;
		bit          in_payload;
		logic [31:0] len_acc;
		int unsigned groups;
		logic [15:0] left;
		logic [15:0] max_len;
		int unsigned mismatches;
		beat_t       beats_due[$];

		function new(bit keep_beats);
			keep = keep_beats;
			max_len = vlpd_pkg::MAX_LEN_RESET;
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			in_payload = 1'b0;
			len_acc = '0;
			groups = 0;
			left = '0;
		endfunction

		function void set_max(logic [15:0] v);
			max_len = v;
		endfunction

		function int pending();
			return beats_due.size();
		endfunction

		function bit mid_frame();
			return in_payload || groups != 0;
		endfunction

		function void note(logic [7:0] data, logic last, logic err);
			beat_t b;
			b.data = data;
			b.last = last;
			b.err = err;
			if (keep) begin
				beats_due.push_back(b);
			end
		endfunction

		function void take_byte(logic [7:0] b);
			logic [63:0] wide;
			if (in_payload) begin
				left = left - 16'd1;
				if (left == 16'd0) begin
					note(b, 1'b1, 1'b0);
					restart();
				end else begin
					note(b, 1'b0, 1'b0);
				end
				return;
			end
			// groups past bit 31 fall off, as in a 32-bit varint read
			wide = 64'(b & vlpd_pkg::GROUP_MASK) << (7 * groups);
			len_acc = len_acc | wide[31:0];
			if ((b & vlpd_pkg::MORE_FLAG) != 8'd0) begin
				groups++;
				if (groups >= vlpd_pkg::MAX_PREFIX_BYTES) begin
					note(8'd0, 1'b0, 1'b1);
					restart();
				end
				return;
			end
			if (len_acc == 32'd0 || len_acc > {16'd0, max_len}) begin
				note(8'd0, 1'b0, 1'b1);
				restart();
				return;
			end
			left = len_acc[15:0];
			in_payload = 1'b1;
			len_acc = '0;
			groups = 0;
		endfunction

		function void check_beat(logic [7:0] data, logic last, logic err);
			beat_t want;
			if (beats_due.size() == 0) begin
				$display("%0t: tx beat with none due: data %h last %b err %b",
					$time, data, last, err);
				mismatches++;
				return;
			end
			want = beats_due.pop_front();
			if (want.data !== data || want.last !== last || want.err !== err) begin
				$display({"%0t: tx mismatch: expected data %h last %b err %b, ",
					"got data %h last %b err %b"},
					$time, want.data, want.last, want.err, data, last, err);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_data;

	vlpd_byte_if   rx_ch ();
	vlpd_result_if tx_ch ();

	varint_length_prefix_deframer_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.rx       (rx_ch),
		.tx       (tx_ch)
	);

	// expected: checks tx. stream_pos: tells the sender where it is in a frame,
	// so broken or noisy input can always be steered back to a prefix start.
	deframe_check expected   = new(1'b1);
	deframe_check stream_pos = new(1'b0);

	bit quiet;            // no idle gaps on either side while set
	bit hold_rx;          // receiver stalls for a long stretch, then clears it
	int unsigned sent_bytes;

	// Opening stream at the reset maximum of 10000:
	//   zero length -> error
	//   five prefix bytes all with the continuation bit -> error on the fifth
	//   length 1 carrying 0xFF
	//   length 2 carrying 0x00, 0x80
	//   10001 (one above the maximum) -> error
	//   length 3 in five bytes, junk above bit 31 in the last one -> dropped
	localparam int OPEN_LEN = 21;
	localparam logic [7:0] OPENING [OPEN_LEN] = '{
		8'h00,
		8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
		8'h01, 8'hFF,
		8'h02, 8'h00, 8'h80,
		8'h91, 8'h4E,
		8'h83, 8'h80, 8'h80, 8'h80, 8'h70, 8'hA5, 8'h5A, 8'h00
	};

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		if ($urandom_range(0, 9) == 0) begin
			return $urandom_range(10, 40);
		end
		return $urandom_range(1, 3);
	endfunction

	// Both channels sampled at the edge; all drives are nonblocking, so the
	// values seen here are the ones that were in place during the last cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_ch.valid && rx_ch.ready) begin
				expected.take_byte(rx_ch.rx_byte);
			end
			if (tx_ch.valid && tx_ch.ready) begin
				expected.check_beat(tx_ch.payload_byte, tx_ch.last_of_message,
					tx_ch.frame_error);
			end
		end
	end

	// Receiver: random stalls, none while quiet, and one long hold on request.
	initial begin
		tx_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_rx) begin
				// long enough for the block to fill and back-pressure rx
				tx_ch.ready <= 1'b0;
				repeat (200) @(posedge clk);
				hold_rx = 1'b0;
			end else if (quiet || $urandom_range(0, 3) != 0) begin
				tx_ch.ready <= 1'b1;
				@(posedge clk);
			end else begin
				tx_ch.ready <= 1'b0;
				repeat (gap_len()) @(posedge clk);
			end
		end
	end

	// One rx beat. valid stays high on return so back-to-back beats never
	// drop it; a random gap lowers it and scrambles the byte meanwhile.
	task automatic send_byte(input logic [7:0] b);
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		stream_pos.take_byte(b);
		sent_bytes++;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			rx_ch.valid <= 1'b0;
			rx_ch.rx_byte <= 8'($urandom);
			repeat (gap_len()) @(posedge clk);
		end
	endtask

	// Finish whatever frame is open: payload bytes until the last one, or
	// continuation bytes until a half-read prefix overflows into an error.
	task automatic resync();
		while (stream_pos.mid_frame()) begin
			send_byte(stream_pos.in_payload ? 8'($urandom) : vlpd_pkg::MORE_FLAG);
		end
	endtask

	// Prefix for len in nb bytes (possibly padded), then its payload if the
	// block will take one. junk lands above bit 31 when nb is five.
	task automatic send_frame(input logic [31:0] len, input int nb, input logic [2:0] junk);
		logic [7:0] b;
		for (int i = 0; i < nb; i++) begin
			b = 8'((len >> (7 * i)) & 32'h7F);
			if (i == 4) begin
				b = b | {1'b0, junk, 4'b0000};
			end
			if (i < nb - 1) begin
				b = b | vlpd_pkg::MORE_FLAG;
			end
			send_byte(b);
		end
		resync();
	endtask

	// Sender pause: nothing offered until every due beat has come back.
	task automatic drain_results();
		rx_ch.valid <= 1'b0;
		// the monitor queues a beat accepted at this edge before the count is read
		@(posedge clk);
		while (expected.pending() != 0) @(posedge clk);
	endtask

	task automatic write_max(input logic [15:0] v);
		drain_results();
		// a prefix byte gives no beat; let the block settle past the last one
		repeat (3) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		expected.set_max(v);
		stream_pos.set_max(v);
	endtask

	// Mostly well-formed frames with random payload; the rest are zero,
	// oversized and overlong prefixes, plus raw noise where lengths stay small.
	task automatic random_frame(input logic [15:0] mx);
		int unsigned pick;
		int unsigned cap;
		int unsigned nb;
		logic [31:0] len;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			cap = ($urandom_range(0, 9) == 0) ? 200 : 24;
			len = (mx == 16'd0) ? 32'd1 : $urandom_range(1, (mx < cap) ? mx : cap);
		end else if (pick < 78) begin
			len = '0;
		end else if (pick < 88) begin
			len = $urandom_range(0, 1) ? 32'(mx) + 32'd1 + $urandom_range(0, 500)
				: ($urandom | 32'h0001_0000);
		end else if (pick < 94 || mx > 16'd1000) begin
			repeat (vlpd_pkg::MAX_PREFIX_BYTES)
				send_byte(vlpd_pkg::MORE_FLAG | 8'($urandom_range(0, 127)));
			return;
		end else begin
			repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
			resync();
			return;
		end
		nb = 1;
		while (nb < vlpd_pkg::MAX_PREFIX_BYTES && (len >> (7 * nb)) != 32'd0) nb++;
		if ($urandom_range(0, 3) == 0) begin
			nb = $urandom_range(nb, vlpd_pkg::MAX_PREFIX_BYTES);
		end
		send_frame(len, nb, 3'($urandom));
	endtask

	task automatic run_phase(input logic [15:0] mx, input int frames);
		write_max(mx);
		quiet = ($urandom_range(0, 3) == 0);
		repeat (frames) random_frame(mx);
		quiet = 1'b0;
		if ($urandom_range(0, 2) == 0) begin
			drain_results();
		end
	endtask

	initial begin
		logic [15:0] mx;
		quiet = 1'b0;
		hold_rx = 1'b0;
		sent_bytes = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_data <= '0;
		rx_ch.valid <= 1'b0;
		rx_ch.rx_byte <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening, reset maximum still in force
		for (int i = 0; i < OPEN_LEN; i++) begin
			send_byte(OPENING[i]);
		end
		resync();

		// smallest nonzero maximum, then a zero maximum where every length fails
		run_phase(16'd1, 20);
		run_phase(16'd0, 12);

		// largest maximum: the receiver holds off while 60 payload bytes are
		// offered back to back, so the output register fills and rx stalls
		write_max(16'hFFFF);
		quiet = 1'b1;
		hold_rx = 1'b1;
		send_frame(32'd60, 1, 3'd0);
		quiet = 1'b0;
		drain_results();
		// one above the largest 16-bit length is an error
		send_frame(32'd65536, 3, 3'd0);

		// random phases, each under a fresh maximum
		while (sent_bytes < 1400) begin
			case ($urandom_range(0, 5))
				0: mx = 16'd1;
				1: mx = 16'd0;
				2: mx = 16'hFFFF;
				3: mx = vlpd_pkg::MAX_LEN_RESET;
				default: mx = 16'($urandom_range(2, 400));
			endcase
			run_phase(mx, $urandom_range(8, 25));
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (expected.mismatches == 0) begin
			$display("varint_length_prefix_deframer_top_test: done, clean");
		end else begin
			$display("varint_length_prefix_deframer_top_test: done, errors");
		end
		$finish;
	end

	// Watchdog: fails the run if it goes far beyond the slowest legal run.
	initial begin
		#20000000;
		$display("varint_length_prefix_deframer_top_test: done, errors");
		$finish;
	end

endmodule
